>>> rtl/core/mcs_pkg.sv
package mcs_pkg;

   // Drive kind codes.
   localparam logic [3:0] KIND_NONE          = 4'd0;
   localparam logic [3:0] KIND_DUTY          = 4'd1;
   localparam logic [3:0] KIND_CURRENT       = 4'd2;
   localparam logic [3:0] KIND_CURRENT_REL   = 4'd3;
   localparam logic [3:0] KIND_BRAKE         = 4'd4;
   localparam logic [3:0] KIND_BRAKE_REL     = 4'd5;
   localparam logic [3:0] KIND_RPM           = 4'd6;
   localparam logic [3:0] KIND_POS           = 4'd7;
   localparam logic [3:0] KIND_HANDBRAKE     = 4'd8;
   localparam logic [3:0] KIND_HANDBRAKE_REL = 4'd9;
   localparam logic [3:0] KIND_LAST          = KIND_HANDBRAKE_REL;

   // Request operations.
   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_REFRESH = 1'b1;

   // Response status codes.
   localparam logic [1:0] STATUS_SENT     = 2'd0;
   localparam logic [1:0] STATUS_DISABLED = 2'd1;
   localparam logic [1:0] STATUS_WRONG    = 2'd2;
   localparam logic [1:0] STATUS_NOTHING  = 2'd3;

   // Configuration register indexes.
   localparam logic [3:0] CSR_ENABLED        = 4'd0;
   localparam logic [3:0] CSR_PRIMARY_MODE   = 4'd1;
   localparam logic [3:0] CSR_REVERSE        = 4'd2;
   localparam logic [3:0] CSR_MIN_RPM        = 4'd3;
   localparam logic [3:0] CSR_MAX_RPM        = 4'd4;
   localparam logic [3:0] CSR_ACCEL_LIMIT_ON = 4'd5;
   localparam logic [3:0] CSR_MAX_RPM_PER_MS = 4'd6;
   localparam logic [3:0] CSR_POLE_PAIRS     = 4'd7;

   // Plus and minus one in Q15.16.
   localparam logic signed [31:0] ONE_Q16     = 32'sh0001_0000;
   localparam logic signed [31:0] NEG_ONE_Q16 = -32'sh0001_0000;

   typedef struct packed {
      logic               op;
      logic [3:0]         drive_kind;
      logic signed [31:0] drive_value;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [3:0]         cmd_kind;
      logic signed [47:0] cmd_value;
   } rsp_type;

   typedef struct packed {
      logic        enabled;
      logic [3:0]  primary_mode;
      logic        reverse;
      logic [14:0] min_rpm;
      logic [14:0] max_rpm;
      logic        accel_limit_on;
      logic [31:0] max_rpm_per_ms;
      logic [15:0] pole_pairs;
   } cfg_type;

   // Step strobes from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic eval;
      logic dead;
      logic slew;
      logic scale;
      logic fin;
   } dp_cmd_type;

   // Decision of the evaluation step, read by the controller.
   typedef struct packed {
      logic sent;
      logic shape;
   } dp_status_type;

endpackage

>>> rtl/core/motor_command_shaper_top.sv
// Motor command shaper.
// Requests arrive on the req_ channel (valid/stall): a new drive command or a
// refresh of the stored command, each with a millisecond timestamp. Every request
// produces exactly one response on the rsp_ channel, carrying a status, the kind
// sent and a Q31.16 value. Rpm commands pass a deadband, an optional slew limit,
// a max clamp and pole pair scaling before they go out.
// A non-rpm request goes from evaluation straight to the response register; an rpm
// request walks the shaper in four extra steps in between: deadband, slew, scale, fin.
// Only one request is in flight at a time. The next request is taken in the same
// cycle the waiting response is taken.
// Configuration goes through the csr_ port (valid/ready, always ready), by register
// index, and should only be written while no request is in flight.
// Reset (synchronous, active high) restores the configuration defaults and clears
// the stored command and the rpm history. While the receiver stalls, the response
// register holds its value and no new request is taken.
module motor_command_shaper_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mcs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mcs_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [3:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   mcs_pkg::cfg_type       cfg;
   mcs_pkg::dp_cmd_type    dp_cmd;
   mcs_pkg::dp_status_type dp_status;

   // Register file holding the eight configuration registers.
   mcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer: steps each request through evaluation and, for rpm, the shaper.
   mcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Arithmetic, stored command, rpm history and the response register.
   mcs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .dp_cmd      (dp_cmd),
      .req_payload (req_payload),
      .dp_status   (dp_status),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/core/mcs_csr.sv
module mcs_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [3:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output mcs_pkg::cfg_type cfg
);

   mcs_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled        <= 1'b1;
         cfg_ff.primary_mode   <= mcs_pkg::KIND_RPM;
         cfg_ff.reverse        <= 1'b0;
         cfg_ff.min_rpm        <= 15'd0;
         cfg_ff.max_rpm        <= 15'd12000;
         cfg_ff.accel_limit_on <= 1'b0;
         cfg_ff.max_rpm_per_ms <= 32'd0;
         cfg_ff.pole_pairs     <= 16'd128;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mcs_pkg::CSR_ENABLED:        cfg_ff.enabled        <= csr_wdata[0];
            mcs_pkg::CSR_PRIMARY_MODE:   cfg_ff.primary_mode   <= csr_wdata[3:0];
            mcs_pkg::CSR_REVERSE:        cfg_ff.reverse        <= csr_wdata[0];
            mcs_pkg::CSR_MIN_RPM:        cfg_ff.min_rpm        <= csr_wdata[14:0];
            mcs_pkg::CSR_MAX_RPM:        cfg_ff.max_rpm        <= csr_wdata[14:0];
            mcs_pkg::CSR_ACCEL_LIMIT_ON: cfg_ff.accel_limit_on <= csr_wdata[0];
            mcs_pkg::CSR_MAX_RPM_PER_MS: cfg_ff.max_rpm_per_ms <= csr_wdata;
            mcs_pkg::CSR_POLE_PAIRS:     cfg_ff.pole_pairs     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/core/mcs_ctrl.sv
module mcs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  mcs_pkg::dp_status_type dp_status,
   output mcs_pkg::dp_cmd_type    dp_cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EVAL  = 7'b0000010,
      ST_DEAD  = 7'b0000100,
      ST_SLEW  = 7'b0001000,
      ST_SCALE = 7'b0010000,
      ST_FIN   = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      take_req;

   // A new request is taken when idle, or when the held response leaves this cycle.
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_RESP) && !rsp_stall));
   assign take_req  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      dp_cmd         = '0;
      dp_cmd.capture = take_req;
      dp_cmd.eval    = (state_ff == ST_EVAL);
      dp_cmd.dead    = (state_ff == ST_DEAD);
      dp_cmd.slew    = (state_ff == ST_SLEW);
      dp_cmd.scale   = (state_ff == ST_SCALE);
      dp_cmd.fin     = (state_ff == ST_FIN);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take_req) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (dp_status.sent && dp_status.shape) state_in = ST_DEAD;
            else state_in = ST_RESP;
         end
         ST_DEAD:  state_in = ST_SLEW;
         ST_SLEW:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_FIN;
         ST_FIN:   state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) state_in = take_req ? ST_EVAL : ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/mcs_datapath.sv
module mcs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  mcs_pkg::cfg_type       cfg,
   input  mcs_pkg::dp_cmd_type    dp_cmd,
   input  mcs_pkg::req_type       req_payload,
   output mcs_pkg::dp_status_type dp_status,
   output mcs_pkg::rsp_type       rsp_payload
);

   // Stored command and shaper history.
   logic [3:0]         active_kind_ff;
   logic signed [31:0] active_value_ff;
   logic signed [31:0] last_rpm_ff;
   logic [31:0]        last_ms_ff;

   // Per-request working registers.
   mcs_pkg::req_type   req_ff;
   logic signed [31:0] work_val_ff;
   logic [63:0]        mprod_ff;
   logic signed [31:0] dead_ff;
   logic [40:0]        lim_ff;
   logic signed [31:0] shaped_ff;
   logic signed [47:0] prod_ff;
   mcs_pkg::rsp_type   rsp_ff;

   // Evaluation step.
   logic [1:0]         ev_status;
   logic [3:0]         ev_kind;
   logic signed [31:0] ev_val;
   logic               ev_store;
   logic               ev_checked;
   logic               ev_brake;
   logic signed [31:0] mx32;
   logic signed [31:0] neg_mx32;
   logic signed [47:0] ev_v48;
   logic signed [47:0] ev_out;
   logic [31:0]        dt;
   logic [63:0]        mprod;

   assign mx32     = {1'b0, cfg.max_rpm, 16'h0000};
   assign neg_mx32 = -mx32;
   assign dt       = req_ff.now_ms - last_ms_ff;
   assign mprod    = {32'd0, cfg.max_rpm_per_ms} * {32'd0, dt};

   always_comb begin
      ev_status  = mcs_pkg::STATUS_SENT;
      ev_kind    = active_kind_ff;
      ev_val     = active_value_ff;
      ev_store   = 1'b0;
      ev_checked = req_ff.drive_kind inside {mcs_pkg::KIND_DUTY, mcs_pkg::KIND_CURRENT,
                                             mcs_pkg::KIND_CURRENT_REL, mcs_pkg::KIND_RPM,
                                             mcs_pkg::KIND_POS};
      if (!cfg.enabled) begin
         ev_status = mcs_pkg::STATUS_DISABLED;
      end else if (req_ff.op == mcs_pkg::OP_REFRESH) begin
         if (active_kind_ff == mcs_pkg::KIND_NONE) ev_status = mcs_pkg::STATUS_NOTHING;
      end else if ((req_ff.drive_kind == mcs_pkg::KIND_NONE) ||
                   (req_ff.drive_kind > mcs_pkg::KIND_LAST)) begin
         ev_status = mcs_pkg::STATUS_NOTHING;
      end else if (ev_checked && (req_ff.drive_kind != cfg.primary_mode)) begin
         ev_status = mcs_pkg::STATUS_WRONG;
      end else begin
         ev_store = 1'b1;
         ev_kind  = req_ff.drive_kind;
         ev_val   = req_ff.drive_value;
         case (req_ff.drive_kind)
            mcs_pkg::KIND_DUTY: begin
               if (req_ff.drive_value > mcs_pkg::ONE_Q16) ev_val = mcs_pkg::ONE_Q16;
               else if (req_ff.drive_value < mcs_pkg::NEG_ONE_Q16) ev_val = mcs_pkg::NEG_ONE_Q16;
            end
            mcs_pkg::KIND_RPM: begin
               if (req_ff.drive_value > mx32) ev_val = mx32;
               else if (req_ff.drive_value < neg_mx32) ev_val = neg_mx32;
            end
            default: ;
         endcase
      end
   end

   // Brake kinds go out without the direction sign.
   assign ev_brake = ev_kind inside {mcs_pkg::KIND_BRAKE, mcs_pkg::KIND_BRAKE_REL,
                                     mcs_pkg::KIND_HANDBRAKE, mcs_pkg::KIND_HANDBRAKE_REL};
   assign ev_v48   = {{16{ev_val[31]}}, ev_val};
   assign ev_out   = (ev_brake || !cfg.reverse) ? ev_v48 : -ev_v48;

   assign dp_status.sent  = (ev_status == mcs_pkg::STATUS_SENT);
   assign dp_status.shape = (ev_kind == mcs_pkg::KIND_RPM);

   // Deadband step and limit saturation.
   logic [32:0]        neg33;
   logic [31:0]        mag;
   logic [31:0]        mn;
   logic [31:0]        half_mn;
   logic signed [31:0] dead_val;
   logic               lim_over;
   logic [40:0]        lim_val;

   assign neg33    = -{work_val_ff[31], work_val_ff};
   assign mag      = work_val_ff[31] ? neg33[31:0] : work_val_ff;
   assign mn       = {1'b0, cfg.min_rpm, 16'h0000};
   assign half_mn  = {2'b00, cfg.min_rpm, 15'h0000};
   assign dead_val = (mag < mn) ? ((mag < half_mn) ? 32'sd0 : mn) : work_val_ff;
   assign lim_over = (|mprod_ff[63:41]) || (mprod_ff[40] && (|mprod_ff[39:0]));
   assign lim_val  = lim_over ? {1'b1, 40'd0} : mprod_ff[40:0];

   // Slew step and max clamp.
   logic signed [42:0] r43;
   logic signed [42:0] last43;
   logic signed [42:0] lim43;
   logic signed [42:0] d43;
   logic signed [42:0] s43;
   logic signed [42:0] mx43;
   logic signed [42:0] c43;

   assign r43    = {{11{dead_ff[31]}}, dead_ff};
   assign last43 = {{11{last_rpm_ff[31]}}, last_rpm_ff};
   assign lim43  = {2'b00, lim_ff};
   assign d43    = r43 - last43;
   assign mx43   = {{11{1'b0}}, mx32};

   always_comb begin
      s43 = r43;
      if (cfg.accel_limit_on) begin
         if (d43 > lim43) s43 = last43 + lim43;
         else if (d43 < -lim43) s43 = last43 - lim43;
      end
      c43 = s43;
      if (s43 > mx43) c43 = mx43;
      else if (s43 < -mx43) c43 = -mx43;
   end

   // Pole pair scaling, then floor to Q16 and direction.
   logic signed [48:0] scale_prod;
   logic signed [47:0] q48;
   logic signed [47:0] fin_val;

   assign scale_prod = $signed({{17{shaped_ff[31]}}, shaped_ff}) *
                       $signed({33'd0, cfg.pole_pairs});
   assign q48        = prod_ff >>> 8;
   assign fin_val    = cfg.reverse ? -q48 : q48;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_kind_ff  <= mcs_pkg::KIND_NONE;
         active_value_ff <= 32'sd0;
         last_rpm_ff     <= 32'sd0;
         last_ms_ff      <= 32'd0;
      end else begin
         if (dp_cmd.eval && ev_store) begin
            active_kind_ff  <= ev_kind;
            active_value_ff <= ev_val;
         end
         if (dp_cmd.slew) begin
            last_rpm_ff <= c43[31:0];
            last_ms_ff  <= req_ff.now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) req_ff <= req_payload;
      if (dp_cmd.eval) begin
         work_val_ff <= ev_val;
         mprod_ff    <= mprod;
         if (ev_status == mcs_pkg::STATUS_SENT) begin
            rsp_ff <= '{status: mcs_pkg::STATUS_SENT, cmd_kind: ev_kind, cmd_value: ev_out};
         end else begin
            rsp_ff <= '{status: ev_status, cmd_kind: mcs_pkg::KIND_NONE, cmd_value: 48'sd0};
         end
      end
      if (dp_cmd.dead) begin
         dead_ff <= dead_val;
         lim_ff  <= lim_val;
      end
      if (dp_cmd.slew)  shaped_ff <= c43[31:0];
      if (dp_cmd.scale) prod_ff   <= scale_prod[47:0];
      if (dp_cmd.fin) begin
         rsp_ff <= '{status: mcs_pkg::STATUS_SENT, cmd_kind: mcs_pkg::KIND_RPM,
                     cmd_value: fin_val};
      end
   end

   assign rsp_payload = rsp_ff;

endmodule
